>>> rtl/ptm_pkg.sv
// ============================================================================
// ptm_pkg
// Shared types, widths and codes of the point-in-tetrahedral-mesh test.
// ============================================================================
package ptm_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MINOR_W    = PROD_W + 1;
    localparam int LO_W       = 26;
    localparam int HI_W       = MINOR_W - LO_W;
    localparam int PLO_W      = DIFF_W + LO_W + 1;
    localparam int PHI_W      = DIFF_W + HI_W;
    localparam int SUM_W      = DIFF_W + MINOR_W + 2;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_TETS   = 1024;
    localparam int NODE_AW    = $clog2(MAX_NODES);
    localparam int TET_AW     = $clog2(MAX_TETS);
    localparam int CNT_W      = 11;
    localparam int CORNER_W   = 11;
    localparam int OP_W       = 2;
    localparam int ORIENT_N   = 5;
    localparam int TAG_W      = 3;

    localparam logic [OP_W-1:0] OP_NODE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TET   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_pt;

    typedef enum logic [1:0] {
        K_NODE,
        K_TET,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [TET_AW-1:0]        slot;
        t_pt                      pt;
        logic [4*NODE_AW-1:0]     corners;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_bus;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        t_pt               a;
        t_pt               b;
        t_pt               c;
        t_pt               d;
    } t_ori_req;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic              neg;
        logic              zero;
    } t_ori_res;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_TRD,
        BS_NRD,
        BS_ISS,
        BS_WAIT,
        BS_DEC,
        BS_OUT
    } t_bstate;

    // Exact difference of two coordinates, one bit wider.
    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        return DIFF_W'(p) - DIFF_W'(q);
    endfunction

endpackage

>>> rtl/ptm_if.sv
// ============================================================================
// ptm_if
// Valid/ready channels for input items and query results.
// ============================================================================
interface ptm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [ptm_pkg::OP_W-1:0]               op;
    logic [ptm_pkg::TET_AW-1:0]             slot;
    logic signed [ptm_pkg::COORD_BITS-1:0]  coord_x;
    logic signed [ptm_pkg::COORD_BITS-1:0]  coord_y;
    logic signed [ptm_pkg::COORD_BITS-1:0]  coord_z;
    logic [ptm_pkg::CORNER_W-1:0]           corner_a;
    logic [ptm_pkg::CORNER_W-1:0]           corner_b;
    logic [ptm_pkg::CORNER_W-1:0]           corner_c;
    logic [ptm_pkg::CORNER_W-1:0]           corner_d;

    modport source (output valid, op, slot, coord_x, coord_y, coord_z,
                     corner_a, corner_b, corner_c, corner_d, input ready);
    modport sink   (input valid, op, slot, coord_x, coord_y, coord_z,
                     corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface ptm_out_if;
    logic valid;
    logic ready;
    logic outside;

    modport source (output valid, outside, input ready);
    modport sink   (input valid, outside, output ready);
endinterface

>>> rtl/ptm_front.sv
// ============================================================================
// ptm_front
// Accepts input items, decodes them into commands and queues them.
// ============================================================================
module ptm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ptm_in_if.sink              i_in,
    input  logic                i_pop,
    output ptm_pkg::t_cmd_bus   o_cmd
);

    ptm_pkg::t_cmd      r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    ptm_pkg::t_cmd      w_cmd;
    logic               w_keep, w_push;
    logic [ptm_pkg::CORNER_W-1:0] w_ca, w_cb, w_cc, w_cd;

    // Corner numbers are one-based; zero wraps to the top entry.
    assign w_ca = ptm_pkg::CORNER_W'(i_in.corner_a - 1'b1);
    assign w_cb = ptm_pkg::CORNER_W'(i_in.corner_b - 1'b1);
    assign w_cc = ptm_pkg::CORNER_W'(i_in.corner_c - 1'b1);
    assign w_cd = ptm_pkg::CORNER_W'(i_in.corner_d - 1'b1);

    always_comb begin
        w_cmd.slot    = i_in.slot;
        w_cmd.pt.x    = i_in.coord_x;
        w_cmd.pt.y    = i_in.coord_y;
        w_cmd.pt.z    = i_in.coord_z;
        w_cmd.corners = {w_cd[ptm_pkg::NODE_AW-1:0], w_cc[ptm_pkg::NODE_AW-1:0],
                         w_cb[ptm_pkg::NODE_AW-1:0], w_ca[ptm_pkg::NODE_AW-1:0]};
        w_cmd.kind    = ptm_pkg::K_QUERY;
        w_keep        = 1'b1;
        unique case (i_in.op)
            ptm_pkg::OP_NODE:  w_cmd.kind = ptm_pkg::K_NODE;
            ptm_pkg::OP_TET:   w_cmd.kind = ptm_pkg::K_TET;
            ptm_pkg::OP_QUERY: w_cmd.kind = ptm_pkg::K_QUERY;
            default:           w_keep     = 1'b0;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready && w_keep;
    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> rtl/ptm_orient.sv
// ============================================================================
// ptm_orient
// Six-stage pipeline that gives the exact sign of one orientation
// determinant per cycle.
// ============================================================================
module ptm_orient (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptm_pkg::t_ori_req   i_req,
    output ptm_pkg::t_ori_res   o_res
);

    logic [5:0]                         r_v;
    logic [ptm_pkg::TAG_W-1:0]          r_tag [6];
    logic signed [ptm_pkg::DIFF_W-1:0]  r1_ad [3];
    logic signed [ptm_pkg::DIFF_W-1:0]  r1_b  [3];
    logic signed [ptm_pkg::DIFF_W-1:0]  r1_c  [3];
    logic signed [ptm_pkg::PROD_W-1:0]  r2_p  [6];
    logic signed [ptm_pkg::DIFF_W-1:0]  r2_f  [3];
    logic signed [ptm_pkg::MINOR_W-1:0] r3_m  [3];
    logic signed [ptm_pkg::DIFF_W-1:0]  r3_f  [3];
    logic signed [ptm_pkg::PLO_W-1:0]   r4_lo [3];
    logic signed [ptm_pkg::PHI_W-1:0]   r4_hi [3];
    logic signed [ptm_pkg::SUM_W-1:0]   r5_sum;
    logic                               r6_neg, r6_zero;
    logic signed [ptm_pkg::SUM_W-1:0]   w_sum;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < 3; k++) begin
            w_sum = w_sum + (ptm_pkg::SUM_W'(r4_hi[k]) <<< ptm_pkg::LO_W)
                          + ptm_pkg::SUM_W'(r4_lo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        // Differences against the fourth point.
        r1_ad[0] <= ptm_pkg::sdiff(i_req.a.x, i_req.d.x);
        r1_ad[1] <= ptm_pkg::sdiff(i_req.a.y, i_req.d.y);
        r1_ad[2] <= ptm_pkg::sdiff(i_req.a.z, i_req.d.z);
        r1_b[0]  <= ptm_pkg::sdiff(i_req.b.x, i_req.d.x);
        r1_b[1]  <= ptm_pkg::sdiff(i_req.b.y, i_req.d.y);
        r1_b[2]  <= ptm_pkg::sdiff(i_req.b.z, i_req.d.z);
        r1_c[0]  <= ptm_pkg::sdiff(i_req.c.x, i_req.d.x);
        r1_c[1]  <= ptm_pkg::sdiff(i_req.c.y, i_req.d.y);
        r1_c[2]  <= ptm_pkg::sdiff(i_req.c.z, i_req.d.z);
        // Products of the 2x2 minors; factors reordered as z, y, x.
        r2_p[0] <= r1_b[0] * r1_c[1];
        r2_p[1] <= r1_b[1] * r1_c[0];
        r2_p[2] <= r1_b[2] * r1_c[0];
        r2_p[3] <= r1_b[0] * r1_c[2];
        r2_p[4] <= r1_b[1] * r1_c[2];
        r2_p[5] <= r1_b[2] * r1_c[1];
        r2_f[0] <= r1_ad[2];
        r2_f[1] <= r1_ad[1];
        r2_f[2] <= r1_ad[0];
        for (int k = 0; k < 3; k++) begin
            r3_m[k] <= ptm_pkg::MINOR_W'(r2_p[2*k]) - ptm_pkg::MINOR_W'(r2_p[2*k+1]);
            r3_f[k] <= r2_f[k];
            // The wide minor is split so each multiplier stays narrow.
            r4_lo[k] <= r3_f[k] * $signed({1'b0, r3_m[k][ptm_pkg::LO_W-1:0]});
            r4_hi[k] <= r3_f[k] * $signed(r3_m[k][ptm_pkg::MINOR_W-1:ptm_pkg::LO_W]);
        end
        r5_sum  <= w_sum;
        r6_neg  <= r5_sum[ptm_pkg::SUM_W-1];
        r6_zero <= (r5_sum == '0);
        r_tag[0] <= i_req.tag;
        for (int s = 1; s < 6; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_req.valid};
        end
    end

    assign o_res.valid = r_v[5];
    assign o_res.tag   = r_tag[5];
    assign o_res.neg   = r6_neg;
    assign o_res.zero  = r6_zero;

endmodule

>>> rtl/ptm_back.sv
// ============================================================================
// ptm_back
// Executes queued commands: store writes and the tetrahedron scan.
// ============================================================================
module ptm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptm_pkg::t_cmd_bus           i_cmd,
    output logic                        o_pop,
    input  logic [ptm_pkg::CNT_W-1:0]   i_tet_count,
    output ptm_pkg::t_ori_req           o_req,
    input  ptm_pkg::t_ori_res           i_res,
    ptm_out_if.source                   o_out
);

    localparam logic [2:0] K_LAST = 3'(ptm_pkg::ORIENT_N - 1);
    localparam logic [2:0] N_LAST = 3'd4;

    ptm_pkg::t_bstate               r_state, n_state;
    ptm_pkg::t_pt                   r_node_mem [ptm_pkg::MAX_NODES];
    logic [4*ptm_pkg::NODE_AW-1:0]  r_tet_mem  [ptm_pkg::MAX_TETS];
    ptm_pkg::t_pt                   r_node_q;
    logic [4*ptm_pkg::NODE_AW-1:0]  r_tet_q;
    ptm_pkg::t_pt                   r_cor [4];
    ptm_pkg::t_pt                   r_pt;
    logic [ptm_pkg::CNT_W-1:0]      r_idx;
    logic [2:0]                     r_k;
    logic [ptm_pkg::ORIENT_N-1:0]   r_neg, r_zero;
    logic                           r_res, r_out_valid, r_outside;

    logic [ptm_pkg::CNT_W-1:0]      w_lim, w_next_idx;
    logic [ptm_pkg::NODE_AW-1:0]    w_node_addr;
    logic [1:0]                     w_ck;
    logic                           w_hit, w_node_we, w_tet_we, w_issue, w_out_free;

    assign w_lim = (i_tet_count > ptm_pkg::CNT_W'(ptm_pkg::MAX_TETS))
                 ? ptm_pkg::CNT_W'(ptm_pkg::MAX_TETS) : i_tet_count;
    assign w_next_idx  = r_idx + 1'b1;
    assign w_node_addr = r_tet_q[r_k[1:0]*ptm_pkg::NODE_AW +: ptm_pkg::NODE_AW];
    assign w_ck        = 2'(r_k - 3'd1);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Inside when no substituted sign opposes the tetrahedron's own sign.
    assign w_hit = !r_zero[0] &&
                   (r_neg[0] ? ((~r_neg[4:1] & ~r_zero[4:1]) == 4'd0)
                             : (r_neg[4:1] == 4'd0));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptm_pkg::BS_IDLE:
                if (i_cmd.valid && i_cmd.cmd.kind == ptm_pkg::K_QUERY) begin
                    n_state = (w_lim == '0) ? ptm_pkg::BS_OUT : ptm_pkg::BS_TRD;
                end
            ptm_pkg::BS_TRD:  n_state = ptm_pkg::BS_NRD;
            ptm_pkg::BS_NRD:  if (r_k == N_LAST) n_state = ptm_pkg::BS_ISS;
            ptm_pkg::BS_ISS:  if (r_k == K_LAST) n_state = ptm_pkg::BS_WAIT;
            ptm_pkg::BS_WAIT:
                if (i_res.valid && i_res.tag == K_LAST) n_state = ptm_pkg::BS_DEC;
            ptm_pkg::BS_DEC:
                n_state = (w_hit || w_next_idx == w_lim) ? ptm_pkg::BS_OUT
                                                         : ptm_pkg::BS_TRD;
            ptm_pkg::BS_OUT:  if (w_out_free) n_state = ptm_pkg::BS_IDLE;
            default:          n_state = ptm_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == ptm_pkg::BS_IDLE) && i_cmd.valid;
        w_node_we = o_pop && (i_cmd.cmd.kind == ptm_pkg::K_NODE);
        w_tet_we  = o_pop && (i_cmd.cmd.kind == ptm_pkg::K_TET);
        w_issue   = (r_state == ptm_pkg::BS_ISS);
    end

    always_comb begin
        o_req.valid = w_issue;
        o_req.tag   = r_k;
        o_req.a     = r_cor[0];
        o_req.b     = r_cor[1];
        o_req.c     = r_cor[2];
        o_req.d     = r_cor[3];
        case (r_k)
            3'd1:    o_req.a = r_pt;
            3'd2:    o_req.b = r_pt;
            3'd3:    o_req.c = r_pt;
            3'd4:    o_req.d = r_pt;
            default: o_req.a = r_cor[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[i_cmd.cmd.slot] <= i_cmd.cmd.pt;
        end
        r_node_q <= r_node_mem[w_node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tet_we) begin
            r_tet_mem[i_cmd.cmd.slot] <= i_cmd.cmd.corners;
        end
        r_tet_q <= r_tet_mem[r_idx[ptm_pkg::TET_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pt <= i_cmd.cmd.pt;
        end
        if (r_state == ptm_pkg::BS_NRD && r_k != 3'd0) begin
            r_cor[w_ck] <= r_node_q;
        end
        if (i_res.valid) begin
            r_neg[i_res.tag]  <= i_res.neg;
            r_zero[i_res.tag] <= i_res.zero;
        end
        if (r_state == ptm_pkg::BS_IDLE) begin
            r_res <= 1'b1;
        end else if (r_state == ptm_pkg::BS_DEC) begin
            r_res <= !w_hit;
        end
        if (r_state == ptm_pkg::BS_OUT && w_out_free) begin
            r_outside <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptm_pkg::BS_IDLE;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ptm_pkg::BS_IDLE: r_idx <= '0;
                ptm_pkg::BS_DEC:  r_idx <= w_next_idx;
                default:          r_idx <= r_idx;
            endcase
            if ((r_state == ptm_pkg::BS_NRD && r_k != N_LAST) ||
                (r_state == ptm_pkg::BS_ISS && r_k != K_LAST)) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
            if (r_state == ptm_pkg::BS_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.outside = r_outside;

endmodule

>>> rtl/point_in_tetra_mesh_test.sv
// ============================================================================
// point_in_tetra_mesh_test
// Exact point-in-tetrahedral-mesh test over stored nodes and tetrahedra.
// ============================================================================
// A write of a node or a tetrahedron is stored by the back end and gives
// no result. A query scans the first tet_count tetrahedra (at most 1024)
// and gives one transfer on the output with outside set when none of them
// holds the point; the scan stops at the first tetrahedron that holds it.
// Per tetrahedron the back end reads the tetrahedron store, makes four
// corner reads through the single read port of the node store, issues
// five determinants into the orientation pipeline and waits for the last
// result. Points on a face, edge or corner count as inside, and a flat
// tetrahedron never holds a point. Input items are decoded into a two-entry
// queue, so the input keeps taking items while a query runs until the queue
// fills, and a finished result waits in an output register. Both stores hold
// garbage after reset; a tetrahedron must only name written nodes and a scan
// must only reach written tetrahedra.
module point_in_tetra_mesh_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ptm_pkg::CNT_W-1:0]   i_cfg_data,
    ptm_in_if.sink                      i_in,
    ptm_out_if.source                   o_out
);

    // Upper bound on the tetrahedra a query examines; values above the store
    // depth are clamped in the back end.
    logic [ptm_pkg::CNT_W-1:0] r_tet_count;

    ptm_pkg::t_cmd_bus  w_cmd;
    logic               w_pop;
    ptm_pkg::t_ori_req  w_req;
    ptm_pkg::t_ori_res  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tet_count <= '0;
        end else if (i_cfg_we) begin
            r_tet_count <= i_cfg_data;
        end
    end

    // The front end decodes each transfer and drops the unused op code.
    ptm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd)
    );

    // The back end owns both stores and sequences the scan.
    ptm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_tet_count (r_tet_count),
        .o_req       (w_req),
        .i_res       (w_res),
        .o_out       (o_out)
    );

    // Orientation determinants are evaluated exactly; only the sign leaves.
    ptm_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // The back end never takes a command from an empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd.valid)
        else $error("command popped from empty queue");

    // Each determinant issue is followed by a result that carries its tag.
    a_ori_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.valid |-> ##6 (w_res.valid && w_res.tag == $past(w_req.tag, 6)))
        else $error("orientation result lost or out of order");

    // No result is pending right after reset.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result pending after reset");

endmodule
